// ===== rtl/dhrs_pkg.sv =====
package dhrs_pkg;

    localparam int unsigned TRK_W = 16;
    localparam int unsigned ID_W  = 16;

    localparam logic [2:0] MODE_FIFO  = 3'd0;
    localparam logic [2:0] MODE_SSTF  = 3'd1;
    localparam logic [2:0] MODE_LOOK  = 3'd2;
    localparam logic [2:0] MODE_CLOOK = 3'd3;
    localparam logic [2:0] MODE_FLOOK = 3'd4;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_GRANT = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        KIND_UP,
        KIND_DOWN,
        KIND_ABS,
        KIND_LOW,
        KIND_FIRST
    } pass_kind_t;

    typedef struct packed {
        pass_kind_t kind;
        logic       only_active;
    } pass_cfg_t;

    typedef struct packed {
        logic             w;
        logic [ID_W-1:0]  id;
        logic [TRK_W-1:0] trk;
    } entry_t;

endpackage

// ===== rtl/disk_head_request_scheduler_unit.sv =====
// Track request scheduler with FIFO, SSTF, LOOK, C-LOOK and F-LOOK policies held in one
// queue memory of QUEUE_DEPTH entries. A get runs one or more scan passes over the N queued
// entries through a single shared distance comparator, one entry per cycle (at most three
// passes, usually one), then closes the gap left by the granted entry k with N - k - 1
// memory moves. The queue memory has one read and one write port.
// The block takes one beat at a time; a finished result waits in the output register.
module disk_head_request_scheduler_unit
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_id [15:0], req_track [31:16], head_track [47:32], head_busy [48], zero [55:49]
    input  logic [55:0] s_axis_tdata,
    // opcode [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // grant_id [15:0], grant_track [31:16], grant_set [32], going_up [33], zero [39:34]
    output logic [39:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]  m_axis_tuser
);
    import dhrs_pkg::*;

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t            state_reg;
    logic [2:0]        mode_reg;
    logic              op_reg;
    logic [ID_W-1:0]   id_in_reg;
    logic [TRK_W-1:0]  trk_in_reg;
    logic [TRK_W-1:0]  head_reg;
    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  act_cnt_reg;
    logic              flip_reg;
    logic              set_reg;
    logic              up_reg;
    pass_cfg_t         pass_reg;
    logic              tried_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic              pv_reg;
    logic [CNT_W-1:0]  pidx_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  best_idx_reg;
    logic [TRK_W-1:0]  best_d_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [TRK_W-1:0]  best_trk_reg;
    logic              best_act_reg;
    logic [1:0]        res_reg;
    logic              m_valid_reg;
    logic [1:0]        out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TRK_W-1:0]  out_trk_reg;
    logic              out_set_reg;
    logic              out_up_reg;

    entry_t            mem [QUEUE_DEPTH];
    entry_t            rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [CNT_W-1:0]  pidx_m1;
    logic              add_wait;
    logic              issue;
    logic              rd_wait;
    logic [TRK_W-1:0]  cmp_dist;
    logic              cmp_take;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_up_reg, out_set_reg, out_trk_reg, out_id_reg};

    assign add_wait  = (mode_reg == MODE_FLOOK) && ((act_cnt_reg != '0) || busy_reg);
    assign issue     = (iss_reg < cnt_reg);
    assign rd_wait   = rdata_reg.w ^ flip_reg;
    assign pidx_m1   = pidx_reg - CNT_W'(1);
    assign mem_raddr = iss_reg[IDX_W-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[IDX_W-1:0];
        mem_wdata = '{w: add_wait ^ flip_reg, id: id_in_reg, trk: trk_in_reg};
        if (state_reg == S_START)
        begin
            mem_we = (op_reg == OP_ADD) && (cnt_reg < DEPTH_C);
        end
        else if (state_reg == S_SHIFT)
        begin
            mem_we    = pv_reg;
            mem_waddr = pidx_m1[IDX_W-1:0];
            mem_wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    dhrs_cmp u_cmp
    (
        .cfg     (pass_reg),
        .head    (head_reg),
        .trk     (rdata_reg.trk),
        .in_wait (rd_wait),
        .found   (found_reg),
        .best_d  (best_d_reg),
        .span    (cmp_dist),
        .take    (cmp_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FIFO;
            op_reg         <= OP_ADD;
            id_in_reg      <= '0;
            trk_in_reg     <= '0;
            head_reg       <= '0;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            act_cnt_reg    <= '0;
            flip_reg       <= 1'b0;
            set_reg        <= 1'b0;
            up_reg         <= 1'b1;
            pass_reg       <= '{kind: KIND_FIRST, only_active: 1'b0};
            tried_reg      <= 1'b0;
            iss_reg        <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_d_reg     <= '0;
            best_id_reg    <= '0;
            best_trk_reg   <= '0;
            best_act_reg   <= 1'b0;
            res_reg        <= ST_ADDED;
            m_valid_reg    <= 1'b0;
            out_status_reg <= ST_ADDED;
            out_id_reg     <= '0;
            out_trk_reg    <= '0;
            out_set_reg    <= 1'b0;
            out_up_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_axis_tready && (state_reg != S_FINISH))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg     <= s_axis_tuser;
                        id_in_reg  <= s_axis_tdata[15:0];
                        trk_in_reg <= s_axis_tdata[31:16];
                        head_reg   <= s_axis_tdata[47:32];
                        busy_reg   <= s_axis_tdata[48];
                        state_reg  <= S_START;
                    end
                end
                S_START:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (cnt_reg >= DEPTH_C)
                        begin
                            res_reg <= ST_FULL;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            if (!add_wait)
                            begin
                                act_cnt_reg <= act_cnt_reg + CNT_W'(1);
                            end
                            res_reg <= ST_ADDED;
                        end
                        state_reg <= S_FINISH;
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_reg   <= ST_EMPTY;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        if ((mode_reg == MODE_FLOOK) && (act_cnt_reg == '0))
                        begin
                            flip_reg    <= ~flip_reg;
                            set_reg     <= ~set_reg;
                            act_cnt_reg <= cnt_reg;
                        end
                        pass_reg.only_active <= (mode_reg == MODE_FLOOK);
                        case (mode_reg)
                            MODE_SSTF:
                            begin
                                pass_reg.kind <= KIND_ABS;
                            end
                            MODE_LOOK, MODE_FLOOK:
                            begin
                                pass_reg.kind <= up_reg ? KIND_UP : KIND_DOWN;
                            end
                            MODE_CLOOK:
                            begin
                                pass_reg.kind <= up_reg ? KIND_UP : KIND_LOW;
                            end
                            default:
                            begin
                                pass_reg.kind <= KIND_FIRST;
                            end
                        endcase
                        tried_reg <= 1'b0;
                        iss_reg   <= '0;
                        pv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pv_reg   <= issue;
                    pidx_reg <= iss_reg;
                    if (issue)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (pv_reg && cmp_take)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= pidx_reg;
                        best_d_reg   <= cmp_dist;
                        best_id_reg  <= rdata_reg.id;
                        best_trk_reg <= rdata_reg.trk;
                        best_act_reg <= ~rd_wait;
                    end
                    if (!issue && !pv_reg)
                    begin
                        if (found_reg)
                        begin
                            iss_reg   <= best_idx_reg + CNT_W'(1);
                            state_reg <= S_SHIFT;
                        end
                        else
                        begin
                            iss_reg <= '0;
                            if (((mode_reg == MODE_LOOK) || (mode_reg == MODE_FLOOK)) &&
                                !tried_reg &&
                                ((pass_reg.kind == KIND_UP) || (pass_reg.kind == KIND_DOWN)))
                            begin
                                up_reg        <= ~up_reg;
                                pass_reg.kind <= (pass_reg.kind == KIND_UP) ? KIND_DOWN
                                                                            : KIND_UP;
                                tried_reg     <= 1'b1;
                            end
                            else if ((mode_reg == MODE_CLOOK) && (pass_reg.kind == KIND_UP))
                            begin
                                pass_reg.kind <= KIND_LOW;
                            end
                            else
                            begin
                                pass_reg <= '{kind: KIND_FIRST, only_active: 1'b0};
                            end
                        end
                    end
                end
                S_SHIFT:
                begin
                    pv_reg   <= issue;
                    pidx_reg <= iss_reg;
                    if (issue)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (!issue && !pv_reg)
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (best_act_reg)
                        begin
                            act_cnt_reg <= act_cnt_reg - CNT_W'(1);
                        end
                        if (mode_reg == MODE_CLOOK)
                        begin
                            up_reg <= 1'b1;
                        end
                        res_reg   <= ST_GRANT;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg    <= 1'b1;
                        out_status_reg <= res_reg;
                        out_id_reg     <= (res_reg == ST_GRANT) ? best_id_reg : '0;
                        out_trk_reg    <= (res_reg == ST_GRANT) ? best_trk_reg : '0;
                        out_set_reg    <= set_reg;
                        out_up_reg     <= up_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/dhrs_cmp.sv =====
module dhrs_cmp
(
    input  dhrs_pkg::pass_cfg_t             cfg,
    input  logic [dhrs_pkg::TRK_W-1:0]      head,
    input  logic [dhrs_pkg::TRK_W-1:0]      trk,
    input  logic                            in_wait,
    input  logic                            found,
    input  logic [dhrs_pkg::TRK_W-1:0]      best_d,
    output logic [dhrs_pkg::TRK_W-1:0]      span,
    output logic                            take
);
    import dhrs_pkg::*;

    logic qual;

    always_comb
    begin
        qual = 1'b1;
        span = '0;
        case (cfg.kind)
            KIND_UP:
            begin
                qual = (trk >= head);
                span = trk - head;
            end
            KIND_DOWN:
            begin
                qual = (trk <= head);
                span = head - trk;
            end
            KIND_ABS:
            begin
                span = (trk >= head) ? (trk - head) : (head - trk);
            end
            KIND_LOW:
            begin
                span = trk;
            end
            default:
            begin
                span = '0;
            end
        endcase
        if (cfg.only_active && in_wait)
        begin
            qual = 1'b0;
        end
        take = qual && (!found || (span < best_d));
    end

endmodule

// ===== verif/tb_disk_head_request_scheduler_unit.sv =====
`timescale 1ns / 1ps

module tb_disk_head_request_scheduler_unit;

    import dhrs_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int EXP_SLOTS = 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gid;
        logic [15:0] gtrk;
        logic        gset;
        logic        up;
    } sched_result_t;

    class sched_scoreboard;
        logic [2:0]    mode;
        logic [15:0]   trk [DEPTH];
        logic [15:0]   ident [DEPTH];
        logic          waits [DEPTH];
        int            count;
        logic          scan_up;
        logic          set_idx;
        sched_result_t exp_q [EXP_SLOTS];
        int            exp_rd;
        int            exp_wr;
        int            errors;
        int            grants;
        int            adds;

        function void clear();
            mode = MODE_FIFO;
            count = 0;
            scan_up = 1'b1;
            set_idx = 1'b0;
            exp_rd = 0;
            exp_wr = 0;
            errors = 0;
            grants = 0;
            adds = 0;
        endfunction

        function int outstanding();
            return exp_wr - exp_rd;
        endfunction

        function bit has_active();
            for (int i = 0; i < count; i++)
                if (!waits[i])
                    return 1'b1;
            return 1'b0;
        endfunction

        function int pick_scan(int hd, bit dir_up, bit only_act);
            int pos;
            int best_d;
            int d;
            pos = -1;
            best_d = 0;
            for (int i = 0; i < count; i++) begin
                if (only_act && waits[i])
                    continue;
                if (dir_up) begin
                    if (trk[i] < hd)
                        continue;
                    d = trk[i] - hd;
                end
                else begin
                    if (trk[i] > hd)
                        continue;
                    d = hd - trk[i];
                end
                if (pos < 0 || d < best_d) begin
                    pos = i;
                    best_d = d;
                end
            end
            return pos;
        endfunction

        function int pick_nearest(int hd);
            int pos;
            int best_d;
            int d;
            pos = 0;
            best_d = 0;
            for (int i = 0; i < count; i++) begin
                d = (trk[i] >= hd) ? trk[i] - hd : hd - trk[i];
                if (i == 0 || d < best_d) begin
                    pos = i;
                    best_d = d;
                end
            end
            return pos;
        endfunction

        function int pick_circular(int hd);
            int pos;
            int best_d;
            int d;
            pos = -1;
            best_d = 0;
            for (int i = 0; i < count; i++) begin
                if (scan_up) begin
                    if (trk[i] < hd)
                        continue;
                    d = trk[i] - hd;
                end
                else
                    d = trk[i];
                if (pos < 0 || d < best_d) begin
                    pos = i;
                    best_d = d;
                end
            end
            if (pos < 0) begin
                pos = 0;
                for (int i = 1; i < count; i++)
                    if (trk[i] < trk[pos])
                        pos = i;
            end
            return pos;
        endfunction

        function void note_beat(logic op, logic [15:0] rid, logic [15:0] rtrk,
                                logic [15:0] hd, logic busy);
            sched_result_t r;
            int k;
            r = '0;
            if (op == OP_ADD) begin
                if (count >= DEPTH)
                    r.status = ST_FULL;
                else begin
                    waits[count] = (mode == MODE_FLOOK) && (has_active() || busy);
                    trk[count] = rtrk;
                    ident[count] = rid;
                    count++;
                    adds++;
                    r.status = ST_ADDED;
                end
            end
            else if (count == 0)
                r.status = ST_EMPTY;
            else begin
                k = 0;
                case (mode)
                    MODE_SSTF: k = pick_nearest(hd);
                    MODE_LOOK:
                    begin
                        k = pick_scan(hd, scan_up, 1'b0);
                        if (k < 0) begin
                            scan_up = ~scan_up;
                            k = pick_scan(hd, scan_up, 1'b0);
                        end
                    end
                    MODE_CLOOK:
                    begin
                        k = pick_circular(hd);
                        scan_up = 1'b1;
                    end
                    MODE_FLOOK:
                    begin
                        if (!has_active()) begin
                            for (int i = 0; i < count; i++)
                                waits[i] = ~waits[i];
                            set_idx = ~set_idx;
                        end
                        k = pick_scan(hd, scan_up, 1'b1);
                        if (k < 0) begin
                            scan_up = ~scan_up;
                            k = pick_scan(hd, scan_up, 1'b1);
                        end
                    end
                    default: k = 0;
                endcase
                if (k < 0)
                    k = 0;
                r.gid = ident[k];
                r.gtrk = trk[k];
                for (int i = k; i + 1 < count; i++) begin
                    trk[i] = trk[i + 1];
                    ident[i] = ident[i + 1];
                    waits[i] = waits[i + 1];
                end
                count--;
                grants++;
                r.status = ST_GRANT;
            end
            r.gset = set_idx;
            r.up = scan_up;
            exp_q[exp_wr % EXP_SLOTS] = r;
            exp_wr++;
        endfunction

        function void check_beat(logic [1:0] st, logic [39:0] data);
            sched_result_t e;
            if (outstanding() == 0) begin
                $error("unexpected result beat status=%0d data=%h", st, data);
                errors++;
                return;
            end
            e = exp_q[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (data[15:0] !== e.gid) begin
                $error("grant_id expected %0d actual %0d", e.gid, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.gtrk) begin
                $error("grant_track expected %0d actual %0d", e.gtrk, data[31:16]);
                errors++;
            end
            if (data[32] !== e.gset) begin
                $error("grant_set expected %0d actual %0d", e.gset, data[32]);
                errors++;
            end
            if (data[33] !== e.up) begin
                $error("going_up expected %0d actual %0d", e.up, data[33]);
                errors++;
            end
            if (data[39:34] !== 6'd0) begin
                $error("padding expected 0 actual %0d", data[39:34]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    sched_scoreboard sb;
    int idle_cycles;
    bit stim_done;
    bit hot_sink;

    disk_head_request_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic op, logic [15:0] rid, logic [15:0] rtrk,
                                logic [15:0] hd, logic busy, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, busy, hd, rtrk, rid};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_beat(op, rid, rtrk, hd, busy);
    endtask

    task automatic add_req(logic [15:0] rtrk, logic busy);
        send_request(OP_ADD, 16'($urandom), rtrk, 16'($urandom), busy, 1'b1);
    endtask

    task automatic get_req(logic [15:0] hd);
        send_request(OP_GET, 16'($urandom), 16'($urandom), hd, 1'($urandom), 1'b1);
    endtask

    task automatic set_mode(logic [2:0] m);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [15:0] rand_track();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r < 5)
            return 16'($urandom_range(0, 40));
        return 16'($urandom);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tuser, m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk) begin
        if (hot_sink)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 60) ||
                             (($urandom_range(0, 99) < 3) ? 1'b0 : 1'b0);
    end

    initial begin
        hot_sink = 1'b0;
        forever begin
            repeat ($urandom_range(200, 800)) @(posedge clk);
            hot_sink = 1'b1;
            repeat ($urandom_range(50, 300)) @(posedge clk);
            hot_sink = 1'b0;
        end
    end

    initial begin
        logic [2:0] modes [0:8];
        int n;
        sb = new();
        sb.clear();
        idle_cycles = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADD;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty get, field extremes, SSTF ties, FLOOK busy and swap.
        get_req(16'h0000);
        send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_request(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        get_req(16'hFFFF);
        get_req(16'h0000);
        set_mode(MODE_SSTF);
        add_req(16'd10, 1'b0);
        add_req(16'd30, 1'b0);
        get_req(16'd20);
        get_req(16'd20);
        set_mode(MODE_CLOOK);
        add_req(16'd5, 1'b0);
        add_req(16'd50, 1'b0);
        get_req(16'd60);
        get_req(16'd0);
        set_mode(MODE_FLOOK);
        add_req(16'd100, 1'b1);
        add_req(16'd200, 1'b0);
        get_req(16'd150);
        add_req(16'd120, 1'b0);
        get_req(16'd150);
        get_req(16'd150);
        get_req(16'd150);
        set_mode(3'd7);
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(OP_ADD, 16'(i), rand_track(), 16'($urandom), 1'($urandom), 1'b0);
        while (sb.count > 0)
            send_request(OP_GET, 16'($urandom), 16'($urandom), rand_track(),
                         1'($urandom), 1'b0);

        modes = '{MODE_LOOK, MODE_FLOOK, MODE_SSTF, MODE_CLOOK, MODE_FIFO,
                  3'd5, MODE_FLOOK, MODE_LOOK, 3'd6};
        for (int p = 0; p < 9; p++) begin
            set_mode(modes[p]);
            n = (p == 4 || p == 5 || p == 8) ? 100 : 220;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < ((sb.count < 8) ? 70 : 45))
                    add_req(rand_track(), 1'($urandom));
                else
                    get_req(rand_track());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Ran %0d accepted adds and %0d grants across all five policies,",
                 sb.adds, sb.grants);
        $display("including full-queue drops, empty gets and set swaps.");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
